@@ src/icss_pkg.sv @@
// Shared types, constants and character decode for the IUPAC codon state set block.
`default_nettype none
package icss_pkg;

  localparam int unsigned CODON_COUNT         = 64;
  localparam int unsigned RANK_W              = $clog2(CODON_COUNT);
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
  localparam int unsigned CFG_ADDR_W          = 4;
  localparam int unsigned CFG_DATA_W          = 64;

  localparam logic [CODON_COUNT-1:0] STOP_MASK_RESET = 64'h0105_0000_0000_0000;
  localparam logic [3:0]             ALL_BASES       = 4'd15;

  // register index codes
  localparam logic REG_STOP_MASK = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_RESTART  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PHASE_EMPTY = 2'd0,
    PHASE_ONE   = 2'd1,
    PHASE_TWO   = 2'd2
  } phase_t;

  typedef logic [3:0] base_set_t;

  typedef struct packed {
    logic [7:0] seq_char;
    logic       seq_start;
  } item_t;

  typedef struct packed {
    logic [CODON_COUNT-1:0] codon_set;
    status_t                status;
  } result_t;

  typedef struct packed {
    status_t   status;
    base_set_t first_base;
    base_set_t second_base;
    base_set_t third_base;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } queue_status_t;

  // bit 0 A, bit 1 C, bit 2 G, bit 3 T; zero marks an invalid character
  function automatic base_set_t decode_base(input logic [7:0] c);
    logic [7:0] u;
    base_set_t  s;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    unique case (u)
      "A":           s = 4'd1;
      "C":           s = 4'd2;
      "G":           s = 4'd4;
      "T", "U":      s = 4'd8;
      "R":           s = 4'd5;
      "Y":           s = 4'd10;
      "M":           s = 4'd3;
      "K":           s = 4'd12;
      "S":           s = 4'd6;
      "W":           s = 4'd9;
      "H":           s = 4'd11;
      "B":           s = 4'd14;
      "V":           s = 4'd7;
      "D":           s = 4'd13;
      "N", "-", "?": s = ALL_BASES;
      default:       s = 4'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ src/icss_front.sv @@
// Front end: accepts characters, decodes them and assembles codon commands.
`default_nettype none
module icss_front
  import icss_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire item_t         item,
  input  wire queue_status_t q_stat,
  output logic               push,
  output cmd_t               cmd
);

  phase_t    phase, phase_next;
  base_set_t first_base, second_base;
  base_set_t set;
  logic      accept, restart;

  always_comb begin
    set        = decode_base(item.seq_char);
    item_ready = q_stat.not_full;
    accept     = item_valid & q_stat.not_full;
    restart    = item.seq_start & (phase != PHASE_EMPTY);
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      priority if (restart) begin
        phase_next = (set != 4'd0) ? PHASE_ONE : PHASE_EMPTY;
      end else if (set == 4'd0) begin
        phase_next = PHASE_EMPTY;
      end else begin
        unique case (phase)
          PHASE_EMPTY: phase_next = PHASE_ONE;
          PHASE_ONE:   phase_next = PHASE_TWO;
          PHASE_TWO:   phase_next = PHASE_EMPTY;
          default:     phase_next = PHASE_EMPTY;
        endcase
      end
    end
  end

  always_comb begin
    push             = 1'b0;
    cmd.status       = STATUS_OK;
    cmd.first_base   = first_base;
    cmd.second_base  = second_base;
    cmd.third_base   = set;
    if (accept) begin
      priority if (restart) begin
        push       = 1'b1;
        cmd.status = STATUS_RESTART;
      end else if (set == 4'd0) begin
        push       = 1'b1;
        cmd.status = STATUS_BAD_CHAR;
      end else if (phase == PHASE_TWO) begin
        push       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_EMPTY;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && set != 4'd0 && (restart || phase == PHASE_EMPTY)) begin
      first_base <= set;
    end
    if (accept && !restart && set != 4'd0 && phase == PHASE_ONE) begin
      second_base <= set;
    end
  end

endmodule
`default_nettype wire

@@ src/icss_queue.sv @@
// Short command queue between the front end and the codon expansion back end.
`default_nettype none
module icss_queue
  import icss_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire cmd_t    push_data,
  input  wire logic    pop,
  output cmd_t         head,
  output queue_status_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    head           = entries[rd_ptr];
    stat.not_empty = (count != '0);
    stat.not_full  = (count != CNT_W'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ src/icss_back.sv @@
// Back end: expands a codon command to compatible codons and packs them by sense rank.
`default_nettype none
module icss_back
  import icss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [CODON_COUNT-1:0] stop_codon_mask,
  input  wire cmd_t                   head,
  input  wire queue_status_t          q_stat,
  output logic                        pop,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output result_t                     result
);

  logic [CODON_COUNT-1:0] stop_q;
  logic [RANK_W-1:0]      rank_q [CODON_COUNT];
  logic [CODON_COUNT-1:0] hit;
  logic [CODON_COUNT-1:0] packed_set;
  logic [CODON_COUNT-1:0] sel [CODON_COUNT];

  // rank of each codon among sense codons, registered from the mask together with stop_q
  always_ff @(posedge clk) begin
    stop_q <= stop_codon_mask;
    for (int i = 0; i < CODON_COUNT; i++) begin
      rank_q[i] <= RANK_W'($countones(~stop_codon_mask & ((64'd1 << i) - 64'd1)));
    end
  end

  for (genvar g = 0; g < CODON_COUNT; g++) begin : g_codon
    assign hit[g] = head.first_base[2'(g >> 4)] & head.second_base[2'(g >> 2)]
                  & head.third_base[2'(g)] & ~stop_q[g];
  end

  for (genvar r = 0; r < CODON_COUNT; r++) begin : g_rank
    for (genvar i = 0; i < CODON_COUNT; i++) begin : g_src
      assign sel[r][i] = (rank_q[i] == RANK_W'(r));
    end
    assign packed_set[r] = |(hit & sel[r]);
  end

  assign pop = q_stat.not_empty & (~result_valid | result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.codon_set <= (head.status == STATUS_OK) ? packed_set : '0;
      result.status    <= head.status;
    end
  end

endmodule
`default_nettype wire

@@ src/iupac_codon_state_set.sv @@
// Top level of the IUPAC codon state set block: config register, front end, queue, back end.
`default_nettype none
// Takes one sequence character per cycle while the queue has room and, on every
// third valid character, returns the set of sense codons compatible with the
// triplet, packed by sense rank after removing codons marked in stop_codon_mask.
// Invalid characters and a restart in mid-codon give an error item with an empty
// set. Throughput is one item per cycle in both directions while the queue has
// room and results are taken; a result passes through a queue entry and then the
// output register, where it is held until taken. The front end decodes and
// tracks the codon phase, a QUEUE_DEPTH entry queue decouples it from the back
// end, whose combinational expansion and rank-packing network feeds the output
// register. The rank table is registered from the stop mask, following writes.
module iupac_codon_state_set
  import icss_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic [CODON_COUNT-1:0] stop_codon_mask;
  queue_status_t          q_stat;
  logic                   push, pop;
  cmd_t                   push_cmd, head;
  logic                   reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_STOP_MASK);
  assign prdata  = reg_hit ? stop_codon_mask : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_codon_mask <= STOP_MASK_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      stop_codon_mask <= pwdata;
    end
  end

  icss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_stat     (q_stat),
    .push       (push),
    .cmd        (push_cmd)
  );

  icss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  icss_back u_back (
    .clk             (clk),
    .rst             (rst),
    .stop_codon_mask (stop_codon_mask),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result)
  );

`ifndef ASSERT_OFF
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != STATUS_OK) |-> (result.codon_set == '0))
    else $error("error item carries codon bits");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> q_stat.not_full)
    else $error("push into full queue");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.not_empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

@@ tb/iupac_codon_state_set_tb.sv @@
// Testbench for iupac_codon_state_set: random and directed character streams checked against a codon-set predictor.
`default_nettype none
module iupac_codon_state_set_tb
  import icss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int REG_UNUSED = 1;
  localparam int LONG_HOLD  = 100;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  item_t                 item = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  item_t       pending_items[$];
  result_t     expected_results[$];
  logic [63:0] stop_mask_model = STOP_MASK_RESET;
  phase_t      codon_phase_model = PHASE_EMPTY;
  base_set_t   first_base_model = '0;
  base_set_t   second_base_model = '0;
  int          mismatch_count = 0;
  int          results_taken = 0;
  int          send_gap = 0;
  int          send_burst = 0;
  int          recv_gap = 0;
  int          recv_burst = 0;
  int          hold_left = 0;
  string       iupac_chars = "ACGTURYMKSWHBVDN-?";
  string       plain_bases = "ACGT";

  iupac_codon_state_set uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic base_set_t base_set_of(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (up)
      "A":           return 4'b0001;
      "C":           return 4'b0010;
      "G":           return 4'b0100;
      "T", "U":      return 4'b1000;
      "R":           return 4'b0101;
      "Y":           return 4'b1010;
      "M":           return 4'b0011;
      "K":           return 4'b1100;
      "S":           return 4'b0110;
      "W":           return 4'b1001;
      "H":           return 4'b1011;
      "B":           return 4'b1110;
      "V":           return 4'b0111;
      "D":           return 4'b1101;
      "N", "-", "?": return 4'b1111;
      default:       return 4'b0000;
    endcase
  endfunction

  // walk codon indexes in order, skipping stops, so the sense rank is a running count
  function automatic logic [63:0] sense_codon_set(input logic [63:0] stops, input base_set_t b1,
                                                  input base_set_t b2, input base_set_t b3);
    logic [63:0] acc;
    int          rank;
    logic [5:0]  ci;
    acc  = '0;
    rank = 0;
    for (int idx = 0; idx < 64; idx++) begin
      ci = idx[5:0];
      if (!stops[idx]) begin
        if (b1[ci[5:4]] && b2[ci[3:2]] && b3[ci[1:0]]) acc[rank] = 1'b1;
        rank++;
      end
    end
    return acc;
  endfunction

  task automatic advance_codon_state(input item_t it);
    base_set_t bs;
    result_t   r;
    bs = base_set_of(it.seq_char);
    if (it.seq_start && codon_phase_model != PHASE_EMPTY) begin
      codon_phase_model = PHASE_EMPTY;
      if (bs != 0) begin
        first_base_model  = bs;
        codon_phase_model = PHASE_ONE;
      end
      r.codon_set = '0;
      r.status    = STATUS_RESTART;
      expected_results = {expected_results, r};
    end else if (bs == 0) begin
      codon_phase_model = PHASE_EMPTY;
      r.codon_set = '0;
      r.status    = STATUS_BAD_CHAR;
      expected_results = {expected_results, r};
    end else begin
      case (codon_phase_model)
        PHASE_EMPTY: begin
          first_base_model  = bs;
          codon_phase_model = PHASE_ONE;
        end
        PHASE_ONE: begin
          second_base_model = bs;
          codon_phase_model = PHASE_TWO;
        end
        default: begin
          codon_phase_model = PHASE_EMPTY;
          r.codon_set = sense_codon_set(stop_mask_model, first_base_model, second_base_model, bs);
          r.status    = STATUS_OK;
          expected_results = {expected_results, r};
        end
      endcase
    end
  endtask

  // mostly back-to-back, sometimes short gaps, rarely long ones, with bursts of no gaps
  task automatic next_gap(inout int burst_left, output int gap);
    int r;
    r = $urandom_range(0, 99);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if (r < 3) begin
      burst_left = $urandom_range(20, 60);
    end else if (r < 45) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(15, 40);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        next_gap(send_burst, send_gap);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result codon_set %h status %0d", $time,
                   result.codon_set, result.status);
        end else begin
          want = expected_results.pop_front();
          if (result.codon_set !== want.codon_set) begin
            mismatch_count++;
            $display("%0t: codon_set expected %h got %h", $time, want.codon_set,
                     result.codon_set);
          end
          if (result.status !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d got %0d", $time, want.status, result.status);
          end
        end
        if (results_taken == 60 || results_taken == 250) hold_left = LONG_HOLD;
        else next_gap(recv_burst, recv_gap);
      end
      if (item_valid && item_ready) advance_codon_state(item);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) || psel || rst) idle = 0;
      else idle++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic push_item(input logic [7:0] ch, input logic start);
    item_t it;
    it.seq_char  = ch;
    it.seq_start = start;
    pending_items = {pending_items, it};
  endtask

  function automatic logic [7:0] valid_char();
    logic [7:0] c;
    if ($urandom_range(0, 1)) c = plain_bases[$urandom_range(0, 3)];
    else c = iupac_chars[$urandom_range(0, iupac_chars.len() - 1)];
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (base_set_of(c) != 0);
    return c;
  endfunction

  // well-formed sequences with occasional bad characters and mid-codon restarts, plus raw noise
  task automatic add_random(input int count);
    int added;
    int n_codons;
    int r;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) != 0) begin
        n_codons = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        for (int k = 0; k < 3 * n_codons; k++) begin
          r = $urandom_range(0, 99);
          if (r < 3) push_item(junk_char(), 1'($urandom_range(0, 1)));
          else if (r < 5 && k != 0) push_item(valid_char(), 1'b1);
          else push_item(valid_char(), k == 0);
          added++;
        end
      end else begin
        push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input int index, input logic [63:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(8 * index);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == int'(REG_STOP_MASK)) stop_mask_model = data;
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    @(negedge clk);
    add_random(count);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    push_item("A", 1'b1); push_item("T", 1'b0); push_item("G", 1'b0);
    push_item("t", 1'b0); push_item("a", 1'b0); push_item("a", 1'b0);
    push_item("N", 1'b0); push_item("N", 1'b0); push_item("N", 1'b0);
    push_item("-", 1'b0); push_item("?", 1'b0); push_item("u", 1'b0);
    push_item("@", 1'b0);
    push_item("A", 1'b0); push_item(8'hff, 1'b0);
    push_item("A", 1'b0); push_item("C", 1'b0); push_item("G", 1'b1);
    push_item("C", 1'b0); push_item("T", 1'b0);
    push_item("A", 1'b0); push_item(8'h00, 1'b1);
    push_item("C", 1'b1); push_item("G", 1'b0); push_item("G", 1'b0);
    run_phase(300);
    cfg_write(REG_STOP_MASK, 64'h0);
    run_phase(150);
    cfg_write(REG_STOP_MASK, {64{1'b1}});
    run_phase(100);
    cfg_write(REG_STOP_MASK, {$urandom, $urandom});
    run_phase(150);
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    run_phase(100);
    cfg_write(REG_STOP_MASK, {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
    run_phase(125);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
